// ----- sv/aspd_pkg.sv -----
// Shared types, store sizes and colour helper functions for the screen
// attribute pixel decoder. No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps

package aspd_pkg;

    // Store sizes and address widths.
    localparam int BITMAP_BYTES  = 6144;
    localparam int ATTR_BYTES    = 6144;
    localparam int PALETTE_SIZE  = 64;
    localparam int BITMAP_AW     = $clog2(BITMAP_BYTES);
    localparam int ATTR_AW       = $clog2(ATTR_BYTES);
    localparam int PALETTE_AW    = $clog2(PALETTE_SIZE);

    // Screen geometry and fixed values.
    localparam logic [7:0]  SCREEN_ROWS    = 8'd192;
    localparam logic [12:0] MG1_OUTER_BASE = 13'd3072;
    localparam logic [7:0]  ATTR_DEFAULT   = 8'h38;
    localparam logic [7:0]  LEVEL_BRIGHT   = 8'hFF;
    localparam logic [7:0]  LEVEL_NORMAL   = 8'hC0;

    // Item actions.
    typedef enum logic [1:0] {
        ACT_WR_BITMAP  = 2'd0,
        ACT_WR_ATTR    = 2'd1,
        ACT_WR_PALETTE = 2'd2,
        ACT_QUERY      = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LINEAR_ROWS  = 2'd0,
        CFG_ATTR_MODE    = 2'd1,
        CFG_ATTR_SHIFT   = 2'd2,
        CFG_PALETTE_MODE = 2'd3
    } t_cfg_reg;

    // Attribute lookup modes.
    typedef enum logic [1:0] {
        ATTR_ROWS     = 2'd0,
        ATTR_CELLS8X1 = 2'd1,
        ATTR_MG1      = 2'd2,
        ATTR_NONE     = 2'd3
    } t_attr_mode;

    // Interleaved thirds layout: third, pixel line in cell, cell row, column.
    function automatic logic [12:0] thirds_address(input logic [7:0] y,
                                                   input logic [4:0] col);
        thirds_address = {y[7:6], y[2:0], y[5:3], col};
    endfunction

    // Spread a 3-bit level over 8 bits.
    function automatic logic [7:0] expand3(input logic [2:0] v);
        expand3 = {v, v, v[2:1]};
    endfunction

endpackage

// ----- sv/attribute_screen_pixel_decoder.sv -----
// Top level of the screen attribute pixel decoder: configuration registers,
// the three-stage query pipeline and the three stores. Depends on aspd_pkg and aspd_ram.
`timescale 1ns / 1ps

// The block accepts one word per clock unless a result waits on the output, and
// returns one colour word for each pixel query with a row below 192; store writes
// and off-screen queries give no result. The bitmap and attribute stores are read
// at the edge that accepts a query, the palette store is then read with the colour
// index, and the colour is formed into the output register after that. The whole
// pipeline advances together and holds while a result waits on the output, so the
// sustained rate is one word per cycle when the output is always taken. The
// stores need no clearing after reset; their contents are undefined until written.
module attribute_screen_pixel_decoder
    import aspd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [12:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_x,
    input  logic [7:0]  i_y,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [5:0]  o_colour_index
);

    // Configuration registers.
    logic       r_linear_rows;
    t_attr_mode r_attr_mode;
    logic [1:0] r_attr_shift;
    logic       r_palette_mode;

    // Pipeline registers.
    logic       r_s1_valid;
    logic [2:0] r_s1_xbit;
    logic       r_s1_attr_none;
    logic       r_s1_attr_hit;
    logic       r_s2_valid;
    logic [5:0] r_s2_idx;
    logic       r_s2_pal;
    logic       r_out_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic [5:0] r_idx;

    // Combinational signals.
    t_action     w_action;
    logic        w_adv;
    logic        w_in_acc;
    logic        w_query_ok;
    logic [4:0]  w_col;
    logic [12:0] n_bitmap_addr;
    logic [12:0] n_attr_addr;
    logic [7:0]  w_y_shifted;
    logic [4:0]  w_outer_col;
    logic [4:0]  w_inner_col;
    logic        w_bm_we;
    logic        w_at_we;
    logic        w_pal_we;
    logic [7:0]  w_bitmap_q;
    logic [7:0]  w_attr_q;
    logic [7:0]  w_pal_q;
    logic        w_bit;
    logic [7:0]  w_attr;
    logic [5:0]  n_idx;
    logic [2:0]  w_blue_level;
    logic [7:0]  w_on;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    // The pipeline moves when the output register is empty or being emptied.
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign w_in_acc    = i_in_valid && w_adv;
    assign w_action    = t_action'(i_action);
    assign w_query_ok  = w_in_acc && (w_action == ACT_QUERY) && (i_y < SCREEN_ROWS);
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_rows  <= 1'b0;
            r_attr_mode    <= ATTR_ROWS;
            r_attr_shift   <= 2'd3;
            r_palette_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_LINEAR_ROWS:  r_linear_rows  <= i_cfg_data[0];
                CFG_ATTR_MODE:    r_attr_mode    <= t_attr_mode'(i_cfg_data[1:0]);
                CFG_ATTR_SHIFT:   r_attr_shift   <= i_cfg_data[1:0];
                CFG_PALETTE_MODE: r_palette_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bitmap byte address for the queried pixel.
    assign w_col = i_x[7:3];
    assign n_bitmap_addr = r_linear_rows ? {i_y, w_col} : thirds_address(i_y, w_col);

    // Attribute byte address; the mixed mode splits the screen into an outer
    // 8x8 table and a middle 8x1 table.
    assign w_y_shifted = i_y >> r_attr_shift;
    assign w_outer_col = (w_col < 5'd8) ? w_col : w_col - 5'd16;
    assign w_inner_col = w_col - 5'd8;

    always_comb begin
        case (r_attr_mode)
            ATTR_CELLS8X1: n_attr_addr = thirds_address(i_y, w_col);
            ATTR_MG1: begin
                if (w_col inside {[5'd8:5'd23]}) begin
                    n_attr_addr = {1'b0, i_y, w_inner_col[3:0]};
                end else begin
                    n_attr_addr = MG1_OUTER_BASE + {4'b0, i_y[7:3], w_outer_col[3:0]};
                end
            end
            default: n_attr_addr = {w_y_shifted, w_col};
        endcase
    end

    // Store write enables; out-of-range addresses are dropped.
    assign w_bm_we  = w_in_acc && (w_action == ACT_WR_BITMAP)
                      && ({1'b0, i_address} < 14'(BITMAP_BYTES));
    assign w_at_we  = w_in_acc && (w_action == ACT_WR_ATTR)
                      && ({1'b0, i_address} < 14'(ATTR_BYTES));
    assign w_pal_we = w_in_acc && (w_action == ACT_WR_PALETTE)
                      && ({1'b0, i_address} < 14'(PALETTE_SIZE));

    aspd_ram #(.WIDTH(8), .DEPTH(BITMAP_BYTES)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_bm_we),
        .i_waddr (i_address[BITMAP_AW-1:0]),
        .i_wdata (i_data),
        .i_re    (w_adv),
        .i_raddr (n_bitmap_addr[BITMAP_AW-1:0]),
        .o_rdata (w_bitmap_q)
    );

    aspd_ram #(.WIDTH(8), .DEPTH(ATTR_BYTES)) u_attr (
        .i_clk   (i_clk),
        .i_we    (w_at_we),
        .i_waddr (i_address[ATTR_AW-1:0]),
        .i_wdata (i_data),
        .i_re    (w_adv),
        .i_raddr (n_attr_addr[ATTR_AW-1:0]),
        .o_rdata (w_attr_q)
    );

    // Stage one: pick ink or paper from the fetched bytes.
    assign w_bit  = w_bitmap_q[~r_s1_xbit];
    assign w_attr = r_s1_attr_none ? ATTR_DEFAULT : (r_s1_attr_hit ? w_attr_q : 8'h00);
    assign n_idx  = {w_attr[7:6], w_bit ? {1'b0, w_attr[2:0]} : {1'b1, w_attr[5:3]}};

    aspd_ram #(.WIDTH(8), .DEPTH(PALETTE_SIZE)) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_address[PALETTE_AW-1:0]),
        .i_wdata (i_data),
        .i_re    (w_adv),
        .i_raddr (n_idx[PALETTE_AW-1:0]),
        .o_rdata (w_pal_q)
    );

    // Stage two: turn the index into colour levels.
    assign w_blue_level = (w_pal_q[1:0] != 2'b00) ? {w_pal_q[1:0], 1'b1} : 3'b000;
    assign w_on         = r_s2_idx[4] ? LEVEL_BRIGHT : LEVEL_NORMAL;

    always_comb begin
        if (r_s2_pal) begin
            n_red   = expand3(w_pal_q[4:2]);
            n_green = expand3(w_pal_q[7:5]);
            n_blue  = expand3(w_blue_level);
        end else begin
            n_red   = r_s2_idx[1] ? w_on : 8'h00;
            n_green = r_s2_idx[2] ? w_on : 8'h00;
            n_blue  = r_s2_idx[0] ? w_on : 8'h00;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_query_ok;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_xbit      <= i_x[2:0];
            r_s1_attr_none <= (r_attr_mode == ATTR_NONE);
            r_s1_attr_hit  <= ({1'b0, n_attr_addr} < 14'(ATTR_BYTES));
            r_s2_idx       <= n_idx;
            r_s2_pal       <= r_palette_mode;
            r_red          <= n_red;
            r_green        <= n_green;
            r_blue         <= n_blue;
            r_idx          <= r_s2_idx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_colour_index = r_idx;

    // A store write never starts a query in the pipeline.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_action != ACT_QUERY)) |=> !r_s1_valid)
        else $error("store write entered the query pipeline");

    // An off-screen query gives no result.
    a_offscreen_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_action == ACT_QUERY) && (i_y >= SCREEN_ROWS)) |=> !r_s1_valid)
        else $error("off-screen query entered the pipeline");

    // A query in stage one reaches stage two when the pipeline moves.
    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv) |=> r_s2_valid)
        else $error("query lost between stage one and stage two");

    // Fixed colours only take the levels zero, normal or bright.
    a_fixed_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_pal && w_adv) |=>
        ((o_red == 8'h00) || (o_red == LEVEL_NORMAL) || (o_red == LEVEL_BRIGHT)))
        else $error("fixed colour level out of set");

    // A stall freezes the inner stages; the index of an empty slot may be unknown.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ((r_s2_idx === $past(r_s2_idx)) && $stable(r_s1_valid)
                    && $stable(r_s2_valid)))
        else $error("pipeline moved during a stall");

endmodule

// ----- sv/aspd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the bitmap, attribute and palette stores.
`timescale 1ns / 1ps

module aspd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read in the same cycle as a write to the same entry returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the screen attribute pixel decoder.
// Depends on aspd_pkg and the attribute_screen_pixel_decoder RTL; needs nothing else.
`timescale 1ns / 1ps

import aspd_pkg::*;

// Expected colour of one pixel query.
typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] colour_index;
} t_pixel_colour;

// Mirror of the three stores and the settings, plus the queue of colours
// that the block still owes.
class screen_colour_tracker;
    logic [7:0] bitmap_bytes [BITMAP_BYTES];
    logic [7:0] attr_bytes [ATTR_BYTES];
    logic [7:0] palette_bytes [PALETTE_SIZE];
    bit bitmap_known [BITMAP_BYTES];
    bit attr_known [ATTR_BYTES];
    bit palette_known [PALETTE_SIZE];

    bit linear_rows;
    t_attr_mode attr_mode;
    logic [1:0] attr_shift;
    bit palette_on;

    t_pixel_colour pending_colours[$];
    int failures;
    int colours_checked;

    function new();
        linear_rows = 1'b0;
        attr_mode = ATTR_ROWS;
        attr_shift = 2'd3;
        palette_on = 1'b0;
        failures = 0;
        colours_checked = 0;
    endfunction

    // Only the low bits of a register write matter.
    function void set_register(t_cfg_reg reg_index, logic [7:0] value);
        case (reg_index)
            CFG_LINEAR_ROWS: linear_rows = value[0];
            CFG_ATTR_MODE: attr_mode = t_attr_mode'(value[1:0]);
            CFG_ATTR_SHIFT: attr_shift = value[1:0];
            CFG_PALETTE_MODE: palette_on = value[0];
            default: ;
        endcase
    endfunction

    // Screen thirds of 2 KB, then pixel line in the cell, then cell row.
    function int interleaved_addr(int col, int y);
        return (y / 64) * 2048 + (y % 8) * 256 + ((y / 8) % 8) * 32 + col;
    endfunction

    function int bitmap_addr(int x, int y);
        if (linear_rows)
            return y * 32 + x / 8;
        return interleaved_addr(x / 8, y);
    endfunction

    // Attribute byte address for a pixel, or -1 when no store is read.
    function int attr_addr(int x, int y);
        int col;
        col = x / 8;
        case (attr_mode)
            ATTR_ROWS: return (y >> attr_shift) * 32 + col;
            ATTR_CELLS8X1: return interleaved_addr(col, y);
            ATTR_MG1: begin
                if (col < 8)
                    return int'(MG1_OUTER_BASE) + (y / 8) * 16 + col;
                if (col >= 24)
                    return int'(MG1_OUTER_BASE) + (y / 8) * 16 + col - 16;
                return y * 16 + col - 8;
            end
            default: return -1;
        endcase
    endfunction

    function logic [7:0] attr_byte(int x, int y);
        int addr;
        addr = attr_addr(x, y);
        if (addr < 0)
            return ATTR_DEFAULT;
        if (addr >= ATTR_BYTES)
            return 8'h00;
        return attr_bytes[addr];
    endfunction

    // Bright and flash in the top pair, then ink or paper.
    function logic [5:0] colour_index(int x, int y);
        logic [7:0] pixels;
        logic [7:0] attr;
        logic lit;
        pixels = bitmap_bytes[bitmap_addr(x, y)];
        attr = attr_byte(x, y);
        lit = pixels[7 - (x % 8)];
        return {attr[7:6], lit ? {1'b0, attr[2:0]} : {1'b1, attr[5:3]}};
    endfunction

    // A 3-bit level repeated across the byte: v*32 + v*4 + v/2.
    function logic [7:0] spread_level(logic [2:0] level);
        return 8'(int'(level) * 36 + int'(level) / 2);
    endfunction

    function t_pixel_colour pixel_colour(int x, int y);
        t_pixel_colour colour;
        logic [7:0] entry;
        logic [7:0] on_level;
        colour.colour_index = colour_index(x, y);
        if (palette_on) begin
            entry = palette_bytes[colour.colour_index];
            colour.red = spread_level(entry[4:2]);
            colour.green = spread_level(entry[7:5]);
            colour.blue = spread_level(entry[1:0] == 2'b00 ? 3'b000 : {entry[1:0], 1'b1});
        end else begin
            on_level = colour.colour_index[4] ? LEVEL_BRIGHT : LEVEL_NORMAL;
            colour.red = colour.colour_index[1] ? on_level : 8'h00;
            colour.green = colour.colour_index[2] ? on_level : 8'h00;
            colour.blue = colour.colour_index[0] ? on_level : 8'h00;
        end
        return colour;
    endfunction

    // Called once for every input word the block accepts.
    function void note_word(t_action action, logic [12:0] address, logic [7:0] data,
                            logic [7:0] x, logic [7:0] y);
        case (action)
            ACT_WR_BITMAP: begin
                if (address < BITMAP_BYTES) begin
                    bitmap_bytes[address] = data;
                    bitmap_known[address] = 1'b1;
                end
            end
            ACT_WR_ATTR: begin
                if (address < ATTR_BYTES) begin
                    attr_bytes[address] = data;
                    attr_known[address] = 1'b1;
                end
            end
            ACT_WR_PALETTE: begin
                if (address < PALETTE_SIZE) begin
                    palette_bytes[address] = data;
                    palette_known[address] = 1'b1;
                end
            end
            default: begin
                if (y < SCREEN_ROWS)
                    pending_colours.push_back(pixel_colour(x, y));
            end
        endcase
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
        end
    endfunction

    // Called once for every colour word the block hands over.
    function void check_colour(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                               logic [5:0] colour_index);
        t_pixel_colour want;
        if (pending_colours.size() == 0) begin
            $display("%0t: unexpected colour word, expected none, actual r=%0d g=%0d b=%0d i=%0d",
                     $time, red, green, blue, colour_index);
            failures++;
            return;
        end
        want = pending_colours.pop_front();
        colours_checked++;
        compare_field("red", want.red, red);
        compare_field("green", want.green, green);
        compare_field("blue", want.blue, blue);
        compare_field("colour_index", {2'b00, want.colour_index}, {2'b00, colour_index});
    endfunction

    function int pending();
        return pending_colours.size();
    endfunction
endclass

module testbench;
    import aspd_pkg::*;

    localparam int PHASES = 10;
    localparam int WORDS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 200;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic linear;
        t_attr_mode mode;
        logic [1:0] shift;
        logic pal;
    } t_screen_setup;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action = 2'd0;
    logic [12:0] i_address = 13'd0;
    logic [7:0]  i_data = 8'd0;
    logic [7:0]  i_x = 8'd0;
    logic [7:0]  i_y = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [5:0]  o_colour_index;

    screen_colour_tracker tracker;
    bit quiet_phase = 1'b0;
    int words_sent = 0;
    int useful_words = 0;
    int colours_taken = 0;
    int stall_left = 0;
    int next_pause = 0;
    int idle_cycles = 0;

    attribute_screen_pixel_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_data         (i_data),
        .i_x            (i_x),
        .i_y            (i_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_colour_index (o_colour_index)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Random pause before the next word; mostly none, and none in a quiet phase.
    function automatic int draw_pause();
        if (quiet_phase)
            return 0;
        return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 16)) : 0;
    endfunction

    // Colour word receiver: stalls at random, and twice holds off for a long
    // stretch so that the pipeline fills and the input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && i_out_ready) begin
            tracker.check_colour(o_red, o_green, o_blue, o_colour_index);
            next_pause = (colours_taken == 30 || colours_taken == 150) ? LONG_HOLD
                                                                        : draw_pause();
            colours_taken <= colours_taken + 1;
            if (next_pause > 0) begin
                i_out_ready <= 1'b0;
                stall_left <= next_pause;
            end
        end else if (!i_out_ready) begin
            if (stall_left <= 1) begin
                i_out_ready <= 1'b1;
                stall_left <= 0;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one input word and hold it until the block takes it.
    task automatic send_word(t_action action, logic [12:0] address, logic [7:0] data,
                             logic [7:0] x, logic [7:0] y);
        int gap;
        bit ignored;
        gap = draw_pause();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= action;
        i_address <= address;
        i_data <= data;
        i_x <= x;
        i_y <= y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_word(action, address, data, x, y);
        case (action)
            ACT_WR_BITMAP: ignored = address >= BITMAP_BYTES;
            ACT_WR_ATTR: ignored = address >= ATTR_BYTES;
            ACT_WR_PALETTE: ignored = address >= PALETTE_SIZE;
            default: ignored = y >= SCREEN_ROWS;
        endcase
        words_sent++;
        if (!ignored)
            useful_words++;
    endtask

    // Query one on-screen pixel, first writing with random bytes whatever
    // store entries the query would read and that hold nothing yet.
    task automatic query_pixel(logic [7:0] x, logic [7:0] y);
        int addr;
        logic [5:0] entry;
        addr = tracker.bitmap_addr(x, y);
        if (!tracker.bitmap_known[addr])
            send_word(ACT_WR_BITMAP, 13'(addr), 8'($urandom), 8'($urandom), 8'($urandom));
        addr = tracker.attr_addr(x, y);
        if (addr >= 0 && addr < ATTR_BYTES && !tracker.attr_known[addr])
            send_word(ACT_WR_ATTR, 13'(addr), 8'($urandom), 8'($urandom), 8'($urandom));
        if (tracker.palette_on) begin
            entry = tracker.colour_index(x, y);
            if (!tracker.palette_known[entry])
                send_word(ACT_WR_PALETTE, 13'(entry), 8'($urandom), 8'($urandom),
                          8'($urandom));
        end
        send_word(ACT_QUERY, 13'($urandom), 8'($urandom), x, y);
    endtask

    // Write one register; valid stays up across back-to-back writes.
    task automatic write_register(t_cfg_reg reg_index, logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_register(reg_index, value);
    endtask

    // Unused upper bits of each register write carry random noise.
    task automatic load_settings(t_screen_setup setup);
        write_register(CFG_LINEAR_ROWS, {7'($urandom), setup.linear});
        write_register(CFG_ATTR_MODE, {6'($urandom), setup.mode});
        write_register(CFG_ATTR_SHIFT, {6'($urandom), setup.shift});
        write_register(CFG_PALETTE_MODE, {7'($urandom), setup.pal});
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering words, wait for every owed colour, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Fixed settings first, covering both extremes of each register; random after.
    function automatic t_screen_setup planned_setup(int phase);
        t_screen_setup setup;
        case (phase)
            1: setup = '{1'b1, ATTR_ROWS, 2'd0, 1'b0};
            2: setup = '{1'b0, ATTR_CELLS8X1, 2'd3, 1'b1};
            3: setup = '{1'b1, ATTR_MG1, 2'd2, 1'b1};
            4: setup = '{1'b0, ATTR_NONE, 2'd1, 1'b0};
            5: setup = '{1'b0, ATTR_MG1, 2'd0, 1'b0};
            6: setup = '{1'b1, ATTR_NONE, 2'd3, 1'b1};
            7: setup = '{1'b0, ATTR_ROWS, 2'd1, 1'b1};
            default: begin
                setup.linear = 1'($urandom);
                setup.mode = t_attr_mode'($urandom_range(0, 3));
                setup.shift = 2'($urandom);
                setup.pal = 1'($urandom);
            end
        endcase
        return setup;
    endfunction

    // Directed words at the reset settings: store edges, writes past the end
    // of each store and rows below the screen.
    task automatic directed_words();
        send_word(ACT_WR_BITMAP, 13'd0, 8'hFF, 8'h00, 8'h00);
        send_word(ACT_WR_ATTR, 13'd0, 8'hC7, 8'hFF, 8'hFF);
        query_pixel(8'd0, 8'd0);
        query_pixel(8'd7, 8'd0);
        // Bottom right pixel lives in the last bitmap byte.
        send_word(ACT_WR_BITMAP, 13'd6143, 8'h00, 8'hFF, 8'hFF);
        send_word(ACT_WR_ATTR, 13'd767, 8'h3A, 8'h00, 8'h00);
        query_pixel(8'd255, 8'd191);
        send_word(ACT_WR_ATTR, 13'd6143, 8'h00, 8'h00, 8'h00);
        send_word(ACT_WR_BITMAP, 13'd6144, 8'hAA, 8'h00, 8'h00);
        send_word(ACT_WR_ATTR, 13'h1FFF, 8'h55, 8'h00, 8'h00);
        send_word(ACT_WR_PALETTE, 13'd64, 8'hFF, 8'h00, 8'h00);
        send_word(ACT_WR_PALETTE, 13'h1FFF, 8'h00, 8'h00, 8'h00);
        send_word(ACT_WR_PALETTE, 13'd0, 8'h00, 8'h00, 8'h00);
        send_word(ACT_WR_PALETTE, 13'd63, 8'hFF, 8'h00, 8'h00);
        send_word(ACT_QUERY, 13'h1FFF, 8'hFF, 8'h00, 8'd192);
        send_word(ACT_QUERY, 13'h0000, 8'h00, 8'hFF, 8'hFF);
        query_pixel(8'd3, 8'd0);
        query_pixel(8'd255, 8'd191);
        query_pixel(8'd128, 8'd100);
    endtask

    // Mostly pixel queries with their store writes, some loose writes, and
    // some noise: writes past the end of a store and rows below the screen.
    task automatic random_word();
        int pick;
        int lowest;
        t_action action;
        logic [7:0] x;
        pick = $urandom_range(0, 99);
        x = 8'($urandom);
        if (pick < 35) begin
            query_pixel(x, 8'($urandom_range(0, 15)));
        end else if (pick < 65) begin
            query_pixel(x, 8'($urandom_range(0, 191)));
        end else if (pick < 85) begin
            action = t_action'($urandom_range(0, 2));
            case (action)
                ACT_WR_BITMAP: lowest = BITMAP_BYTES;
                ACT_WR_ATTR: lowest = ATTR_BYTES;
                default: lowest = PALETTE_SIZE;
            endcase
            send_word(action, 13'($urandom_range(0, lowest - 1)), 8'($urandom),
                      8'($urandom), 8'($urandom));
        end else if (pick < 93) begin
            action = t_action'($urandom_range(0, 2));
            case (action)
                ACT_WR_BITMAP: lowest = BITMAP_BYTES;
                ACT_WR_ATTR: lowest = ATTR_BYTES;
                default: lowest = PALETTE_SIZE;
            endcase
            send_word(action, 13'($urandom_range(lowest, 8191)), 8'($urandom),
                      8'($urandom), 8'($urandom));
        end else begin
            send_word(ACT_QUERY, 13'($urandom), 8'($urandom), x,
                      8'($urandom_range(192, 255)));
        end
    endtask

    // Main sequence: reset, directed words, then one random stretch per setting.
    initial begin
        int target;
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_words();
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                load_settings(planned_setup(phase));
            end
            quiet_phase = (phase == 3 || phase == 6);
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target) random_word();
        end
        quiet_phase = 1'b0;
        drain();
        $display("Sent %0d input words (%0d acted on) over %0d register settings; %s %0d.",
                 words_sent, useful_words, PHASES, "colour words checked:",
                 tracker.colours_checked);
        $display("Both bitmap layouts, all attribute modes, fixed and palette colours, %s",
                 "ignored writes and off-screen rows were exercised.");
        if (tracker.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
